>>> src/u2da_pkg.sv
// shared constants and types for the unsigned to decimal ascii unit
`timescale 1ns / 1ps
`default_nettype none
package u2da_pkg;

	localparam int VALUE_BITS = 64;
	localparam int MAX_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int CNT_W      = $clog2(VALUE_BITS + 1);
	localparam int REM_W      = $clog2(MAX_DIGITS + 1);
	localparam int DIGIT_W    = 4;
	localparam int CHAR_W     = 6;

	localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
	localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = 4'd5;
	localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'd3;

	typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_t;

	typedef struct packed {
		logic clr;
		logic shift;
	} cell_ctl_t;

endpackage
`default_nettype wire

>>> src/u2da_bcd_cell.sv
// one decimal digit cell of the shift-and-add-3 chain
`timescale 1ns / 1ps
`default_nettype none
module u2da_bcd_cell (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire u2da_pkg::cell_ctl_t            ctl,
	input  wire                                 carry_in,
	output logic                                carry_out,
	output logic [u2da_pkg::DIGIT_W-1:0]        digit
);

	logic [u2da_pkg::DIGIT_W-1:0] digit_q;
	logic [u2da_pkg::DIGIT_W-1:0] adj;

	always_comb begin
		if (digit_q >= u2da_pkg::ADJ_LIMIT) begin
			adj = digit_q + u2da_pkg::ADJ_ADD;
		end else begin
			adj = digit_q;
		end
	end

	assign carry_out = adj[u2da_pkg::DIGIT_W-1];
	assign digit     = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctl.clr) begin
			digit_q <= '0;
		end else if (ctl.shift) begin
			digit_q <= {adj[u2da_pkg::DIGIT_W-2:0], carry_in};
		end
	end

endmodule
`default_nettype wire

>>> src/u2da_emitter.sv
// digit shift line that drops leading zeros and sends ascii beats
`timescale 1ns / 1ps
`default_nettype none
module u2da_emitter (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              load,
	input  wire u2da_pkg::digits_t           digits_in,
	output logic                             active,
	output logic                             strobe,
	output logic [u2da_pkg::CHAR_W-1:0]      digit_char,
	output logic                             last
);

	u2da_pkg::digits_t              dig_q;
	logic [u2da_pkg::REM_W-1:0]     rem_q;
	logic                           act_q;
	logic                           seen_q;
	logic                           strobe_q;
	logic                           last_q;
	logic [u2da_pkg::CHAR_W-1:0]    char_q;
	logic [u2da_pkg::DIGIT_W-1:0]   top;
	logic                           final_pos;
	logic                           emit;

	assign top       = dig_q[u2da_pkg::MAX_DIGITS-1];
	assign final_pos = (rem_q == u2da_pkg::REM_W'(1));
	assign emit      = seen_q || (top != '0) || final_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			seen_q   <= 1'b0;
			rem_q    <= '0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else if (load) begin
			act_q    <= 1'b1;
			seen_q   <= 1'b0;
			rem_q    <= u2da_pkg::REM_W'(u2da_pkg::MAX_DIGITS);
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else if (act_q) begin
			act_q    <= !final_pos;
			seen_q   <= emit;
			rem_q    <= rem_q - u2da_pkg::REM_W'(1);
			strobe_q <= emit;
			last_q   <= final_pos;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dig_q <= digits_in;
		end else if (act_q) begin
			dig_q  <= {dig_q[u2da_pkg::MAX_DIGITS-2:0], {u2da_pkg::DIGIT_W{1'b0}}};
			char_q <= u2da_pkg::ASCII_ZERO + {{(u2da_pkg::CHAR_W-u2da_pkg::DIGIT_W){1'b0}}, top};
		end
	end

	assign active     = act_q;
	assign strobe     = strobe_q;
	assign digit_char = char_q;
	assign last       = last_q;

endmodule
`default_nettype wire

>>> src/unsigned_to_decimal_ascii_unit.sv
// top level: binary to decimal ascii converter built on a row of bcd cells
// the value shifts through the cell row, the emitter loads the digits, then scans them
// the first character comes later for more leading zeros; the last closes each scan
// busy is high while the cell row shifts; a new value is accepted once busy drops, so
// the scan of one value overlaps the conversion of the next; the receiver cannot stall
// reset clears the counter, the cells and the scan control; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none
module unsigned_to_decimal_ascii_unit (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output logic                                busy,
	input  wire  [u2da_pkg::VALUE_BITS-1:0]     value,
	output logic                                strobe,
	output logic [u2da_pkg::CHAR_W-1:0]         digit_char,
	output logic                                last
);

	localparam int ND = u2da_pkg::MAX_DIGITS;

	logic [u2da_pkg::VALUE_BITS-1:0] sh_q;
	logic [u2da_pkg::CNT_W-1:0]      cnt_q;
	logic                            done_q;
	logic                            accept;
	logic                            emit_active;
	u2da_pkg::cell_ctl_t             ctl;
	u2da_pkg::digits_t               digits;
	logic [ND:0]                     carry;

	assign busy   = (cnt_q != '0);
	assign accept = start && !busy;

	assign ctl = '{clr: accept, shift: busy};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == u2da_pkg::CNT_W'(1));
			if (accept) begin
				cnt_q <= u2da_pkg::CNT_W'(u2da_pkg::VALUE_BITS);
			end else if (busy) begin
				cnt_q <= cnt_q - u2da_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sh_q <= value;
		end else if (busy) begin
			sh_q <= {sh_q[u2da_pkg::VALUE_BITS-2:0], 1'b0};
		end
	end

	assign carry[0] = sh_q[u2da_pkg::VALUE_BITS-1];

	for (genvar i = 0; i < ND; i++) begin : g_cell
		u2da_bcd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.carry_in  (carry[i]),
			.carry_out (carry[i+1]),
			.digit     (digits[i])
		);
	end

	u2da_emitter u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (done_q),
		.digits_in  (digits),
		.active     (emit_active),
		.strobe     (strobe),
		.digit_char (digit_char),
		.last       (last)
	);

`ifndef SYNTH
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted beat did not start conversion");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("beat after final character");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !emit_active)
		else $error("cell row unloaded over an active scan");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (digit_char >= 6'd48) && (digit_char <= 6'd57))
		else $error("character out of digit range");

	a_top_carry: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.shift |-> !carry[ND])
		else $error("carry out of top digit");
`endif

endmodule
`default_nettype wire

>>> bench/testbench.sv
// self-checking bench for the unsigned to decimal ascii unit
`timescale 1ns / 1ps
module testbench;

	localparam int TAIL_ITEMS   = 40;
	localparam int RANDOM_ITEMS = 460;
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		logic [u2da_pkg::CHAR_W-1:0] digit;
		logic                        final_char;
	} text_char_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            start = 1'b0;
	logic [u2da_pkg::VALUE_BITS-1:0] value = '0;
	logic                            busy;
	logic                            strobe;
	logic [u2da_pkg::CHAR_W-1:0]     digit_char;
	logic                            last;

	logic [u2da_pkg::VALUE_BITS-1:0] pending_values[$];
	text_char_t                      expected_chars[$];
	int                              mismatches = 0;
	int                              idle_left = 0;
	logic                            calm = 1'b0;

	unsigned_to_decimal_ascii_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.strobe     (strobe),
		.digit_char (digit_char),
		.last       (last)
	);

	always #1 clk = ~clk;

	// decimal text of one value, most significant digit first
	function automatic void queue_decimal_text(input logic [u2da_pkg::VALUE_BITS-1:0] v);
		logic [63:0] rest;
		logic [3:0]  rev[u2da_pkg::MAX_DIGITS];
		int          cnt;
		text_char_t  c;
		rest = 64'(v);
		cnt = 0;
		do begin
			rev[cnt] = 4'(rest % 64'd10);
			rest = rest / 64'd10;
			cnt++;
		end while (rest != 64'd0 && cnt < u2da_pkg::MAX_DIGITS);
		for (int k = 0; k < cnt; k++) begin
			c.digit = u2da_pkg::ASCII_ZERO + u2da_pkg::CHAR_W'(rev[cnt - 1 - k]);
			c.final_char = (k == cnt - 1);
			expected_chars.push_back(c);
		end
	endfunction

	function automatic void note_mismatch(input string what, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s expected %0d got %0d", $realtime, what, exp_v, act_v);
	endfunction

	function automatic logic [63:0] pow10(input int k);
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < k; i++)
			p = p * 64'd10;
		return p;
	endfunction

	// driver
	always @(posedge clk) begin : drive
		logic                            nxt_start;
		logic [u2da_pkg::VALUE_BITS-1:0] nxt_value;
		if (!arst_n) begin
			start <= 1'b0;
			value <= '0;
		end else begin
			nxt_value = value;
			if (start && !busy) begin
				queue_decimal_text(value);
				void'(pending_values.pop_front());
			end
			if ($urandom_range(0, 199) == 0)
				calm = !calm;
			if (idle_left == 0 && !calm && pending_values.size() > TAIL_ITEMS &&
					$urandom_range(0, 15) == 0)
				idle_left = $urandom_range(1, 18);
			if (idle_left > 0) begin
				idle_left--;
				nxt_start = 1'b0;
				nxt_value = {$urandom, $urandom};
			end else if (pending_values.size() > 0) begin
				nxt_start = 1'b1;
				nxt_value = pending_values[0];
			end else begin
				nxt_start = 1'b0;
			end
			start <= nxt_start;
			value <= nxt_value;
		end
	end

	// monitor
	always @(posedge clk) begin : watch
		text_char_t e;
		if (arst_n && strobe) begin
			if (expected_chars.size() == 0) begin
				note_mismatch("unexpected character", 64'd0, 64'(digit_char));
			end else begin
				e = expected_chars.pop_front();
				if (digit_char !== e.digit)
					note_mismatch("digit_char", 64'(e.digit), 64'(digit_char));
				if (last !== e.final_char)
					note_mismatch("last", 64'(e.final_char), 64'(last));
			end
		end
	end

	initial begin : stimulus
		logic [63:0] r;
		int          waited;
		pending_values = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd11, 64'd99, 64'd100,
			64'd12345, 64'hFFFF_FFFF, 64'h1_0000_0000, 64'd999999999999999999,
			64'd1000000000000000000, 64'd9999999999999999999,
			64'd10000000000000000000, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
			64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA,
			64'h5555_5555_5555_5555, 64'd1234567890123456789};
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			case ($urandom_range(0, 3))
				0: r = {$urandom, $urandom};
				1: r = {$urandom, $urandom} >> $urandom_range(0, 63);
				2: r = pow10($urandom_range(0, 19)) + 64'($signed($urandom_range(0, 2)) - 1);
				default: r = 64'($urandom_range(0, 999));
			endcase
			pending_values.push_back(u2da_pkg::VALUE_BITS'(r));
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_values.size() != 0 || start)
			@(posedge clk);
		waited = 0;
		while (expected_chars.size() != 0 && waited < DRAIN_CYCLES) begin
			@(posedge clk);
			waited++;
		end
		if (expected_chars.size() != 0)
			note_mismatch("characters missing", 64'(expected_chars.size()), 64'd0);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : watchdog
		#1000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
